/* rtl/core/tsb_pkg.sv */
// shared types, constants and helpers for the three-stack shared buffer
package tsb_pkg;

	localparam int DEPTH       = 128;
	localparam int VALUE_WIDTH = 32;
	localparam int ADDR_W      = $clog2(DEPTH);
	localparam int CNT_W       = $clog2(DEPTH + 1);
	localparam int NUM_STACKS  = 3;
	localparam int GROUP_SIZE  = 16;
	localparam int NUM_GROUPS  = (DEPTH + GROUP_SIZE - 1) / GROUP_SIZE;

	typedef enum logic [1:0] {
		ST_OK        = 2'd0,
		ST_BAD_STACK = 2'd1,
		ST_FULL      = 2'd2,
		ST_EMPTY     = 2'd3
	} status_t;

	typedef enum logic {
		OP_PUSH = 1'b0,
		OP_POP  = 1'b1
	} op_t;

	// broadcast from the boundary control to every cell of the row
	typedef struct packed {
		logic                   shift_up;
		logic                   shift_down;
		logic [CNT_W-1:0]       start;
		logic [CNT_W-1:0]       used;
		logic [VALUE_WIDTH-1:0] value;
	} cell_ctrl_t;

	// push value into a stored word: sign extend or cut to the word width
	function automatic logic [VALUE_WIDTH-1:0] to_word(input logic [31:0] v);
		to_word = VALUE_WIDTH'(signed'(v));
	endfunction

	// stored word back to the 32-bit result field, sign extended
	function automatic logic [31:0] from_word(input logic [VALUE_WIDTH-1:0] w);
		from_word = 32'(signed'(w));
	endfunction

endpackage

/* rtl/core/tsb_cell.sv */
// one storage cell of the shifting buffer row
module tsb_cell (
	input  logic                                 clk,
	input  tsb_pkg::cell_ctrl_t                  ctrl,
	input  logic [tsb_pkg::ADDR_W-1:0]           index,
	input  logic [tsb_pkg::VALUE_WIDTH-1:0]      lower_word,
	input  logic [tsb_pkg::VALUE_WIDTH-1:0]      upper_word,
	output logic [tsb_pkg::VALUE_WIDTH-1:0]      word,
	output logic [tsb_pkg::VALUE_WIDTH-1:0]      read_word
);

	logic [tsb_pkg::VALUE_WIDTH-1:0] word_q;
	logic [tsb_pkg::CNT_W-1:0]       idx;
	logic [tsb_pkg::CNT_W-1:0]       idx_p1;
	logic                            at_start;

	assign idx      = tsb_pkg::CNT_W'(index);
	assign idx_p1   = idx + tsb_pkg::CNT_W'(1);
	assign at_start = (idx == ctrl.start);

	always_ff @(posedge clk) begin
		if (ctrl.shift_up) begin
			if (at_start) begin
				word_q <= ctrl.value;
			end else if (idx > ctrl.start && idx <= ctrl.used) begin
				word_q <= lower_word;
			end
		end else if (ctrl.shift_down) begin
			// close the gap left by the popped top word
			if (idx >= ctrl.start && idx_p1 < ctrl.used) begin
				word_q <= upper_word;
			end
		end
	end

	assign word      = word_q;
	// only the cell at the segment start drives the read tree on a pop
	assign read_word = (ctrl.shift_down && at_start) ? word_q : '0;

endmodule

/* rtl/core/tsb_ctrl.sv */
// segment boundary registers, request decode and status
module tsb_ctrl (
	input  logic                   clk,
	input  logic                   arst_n,
	input  logic                   accept,
	input  tsb_pkg::op_t           mode,
	input  logic [1:0]             stack_select,
	input  logic [31:0]            push_value,
	output tsb_pkg::cell_ctrl_t    ctrl,
	output tsb_pkg::status_t       status
);

	logic [tsb_pkg::CNT_W-1:0] ends_q [tsb_pkg::NUM_STACKS];
	logic [tsb_pkg::CNT_W-1:0] start;
	logic [tsb_pkg::CNT_W-1:0] stop;
	logic [tsb_pkg::CNT_W-1:0] used;
	logic                      ok;

	assign used = ends_q[2];

	always_comb begin
		unique case (stack_select)
			2'd0: begin
				start = '0;
				stop  = ends_q[0];
			end
			2'd1: begin
				start = ends_q[0];
				stop  = ends_q[1];
			end
			2'd2: begin
				start = ends_q[1];
				stop  = ends_q[2];
			end
			default: begin
				start = '0;
				stop  = '0;
			end
		endcase
	end

	always_comb begin
		priority if (stack_select == 2'd3) begin
			status = tsb_pkg::ST_BAD_STACK;
		end else if (mode == tsb_pkg::OP_PUSH) begin
			status = (used >= tsb_pkg::CNT_W'(tsb_pkg::DEPTH)) ? tsb_pkg::ST_FULL
				: tsb_pkg::ST_OK;
		end else begin
			status = (stop <= start || start >= tsb_pkg::CNT_W'(tsb_pkg::DEPTH)
				|| used > tsb_pkg::CNT_W'(tsb_pkg::DEPTH)) ? tsb_pkg::ST_EMPTY
				: tsb_pkg::ST_OK;
		end
	end

	assign ok              = (status == tsb_pkg::ST_OK);
	assign ctrl.shift_up   = accept && ok && (mode == tsb_pkg::OP_PUSH);
	assign ctrl.shift_down = accept && ok && (mode == tsb_pkg::OP_POP);
	assign ctrl.start      = start;
	assign ctrl.used       = used;
	assign ctrl.value      = tsb_pkg::to_word(push_value);

	// the chosen stack and every later one move their end by one
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			for (int k = 0; k < tsb_pkg::NUM_STACKS; k++) begin
				ends_q[k] <= '0;
			end
		end else begin
			for (int k = 0; k < tsb_pkg::NUM_STACKS; k++) begin
				if (2'(k) >= stack_select) begin
					if (ctrl.shift_up) begin
						ends_q[k] <= ends_q[k] + tsb_pkg::CNT_W'(1);
					end else if (ctrl.shift_down) begin
						ends_q[k] <= ends_q[k] - tsb_pkg::CNT_W'(1);
					end
				end
			end
		end
	end

`ifndef ASSERT_OFF
	ends_ordered_a: assert property (@(posedge clk) disable iff (!arst_n)
		ends_q[0] <= ends_q[1] && ends_q[1] <= ends_q[2]
		&& ends_q[2] <= tsb_pkg::CNT_W'(tsb_pkg::DEPTH))
		else $error("segment ends out of order");

	failed_request_holds_a: assert property (@(posedge clk) disable iff (!arst_n)
		accept && status != tsb_pkg::ST_OK |=>
		$stable(ends_q[0]) && $stable(ends_q[1]) && $stable(ends_q[2]))
		else $error("failed request changed the boundaries");

	push_grows_used_a: assert property (@(posedge clk) disable iff (!arst_n)
		ctrl.shift_up |=> ends_q[2] == tsb_pkg::CNT_W'($past(ends_q[2]) + 1'b1))
		else $error("push did not grow the used region by one");
`endif

endmodule

/* rtl/core/three_stacks_shared_buffer_core.sv */
// top level: three lifo stacks sharing one row of shifting storage cells
// a result is offered once its request has passed the read stage and the output register
// throughput: one request per cycle unless the read stage is stalled; the cell row
//   shifts in the accept cycle and the popped word passes a two-level registered or tree of cell outputs
// a waiting result does not block the next request while the read stage is free (a read
//   stage and an output register sit between the two sides)
// reset clears the three segment ends (all stacks empty) and the valid flags;
//   stored words are not reset and are only read after a push wrote them
module three_stacks_shared_buffer_core (
	input  logic        clk,
	input  logic        arst_n,
	// request stream
	input  logic        s_tvalid,
	output logic        s_tready,
	input  logic [31:0] s_tdata,   // [31:0] push_value
	input  logic [2:0]  s_tuser,   // [0] mode, [2:1] stack_select
	// result stream
	output logic        m_tvalid,
	input  logic        m_tready,
	output logic [31:0] m_tdata,   // [31:0] pop_value
	output logic [1:0]  m_tuser    // [1:0] status
);

	localparam int DEPTH      = tsb_pkg::DEPTH;
	localparam int VW         = tsb_pkg::VALUE_WIDTH;
	localparam int GROUP_SIZE = tsb_pkg::GROUP_SIZE;
	localparam int NUM_GROUPS = tsb_pkg::NUM_GROUPS;

	tsb_pkg::cell_ctrl_t ctrl;
	tsb_pkg::status_t    status;
	tsb_pkg::op_t        mode;
	logic                accept;

	// cell row
	logic [VW-1:0] cell_word [DEPTH];
	logic [VW-1:0] cell_read [DEPTH];

	// read stage: one or per group of cells
	logic [VW-1:0]       grp_or [NUM_GROUPS];
	logic [VW-1:0]       grp_s1 [NUM_GROUPS];
	tsb_pkg::status_t    status_s1;
	logic                s1_valid_q;
	logic                s1_adv;

	// output register
	logic [VW-1:0]       all_or;
	logic [31:0]         data_q;
	tsb_pkg::status_t    status_q;
	logic                out_valid_q;

	assign mode     = tsb_pkg::op_t'(s_tuser[0]);
	assign s1_adv   = s1_valid_q && (!out_valid_q || m_tready);
	assign s_tready = !s1_valid_q || s1_adv;
	assign accept   = s_tvalid && s_tready;

	tsb_ctrl u_ctrl (
		.clk          (clk),
		.arst_n       (arst_n),
		.accept       (accept),
		.mode         (mode),
		.stack_select (s_tuser[2:1]),
		.push_value   (s_tdata),
		.ctrl         (ctrl),
		.status       (status)
	);

	// each cell takes its lower neighbor on a push and its upper one on a pop
	for (genvar i = 0; i < DEPTH; i++) begin : g_cell
		logic [VW-1:0] lower;
		logic [VW-1:0] upper;

		if (i == 0) begin : g_first
			assign lower = '0;
		end else begin : g_mid_lo
			assign lower = cell_word[i-1];
		end

		if (i == DEPTH - 1) begin : g_last
			assign upper = '0;
		end else begin : g_mid_hi
			assign upper = cell_word[i+1];
		end

		tsb_cell u_cell (
			.clk        (clk),
			.ctrl       (ctrl),
			.index      (tsb_pkg::ADDR_W'(i)),
			.lower_word (lower),
			.upper_word (upper),
			.word       (cell_word[i]),
			.read_word  (cell_read[i])
		);
	end

	// first level of the read tree, taken from the words before the shift
	always_comb begin
		for (int g = 0; g < NUM_GROUPS; g++) begin
			grp_or[g] = '0;
			for (int k = 0; k < GROUP_SIZE; k++) begin
				if (g * GROUP_SIZE + k < DEPTH) begin
					grp_or[g] = grp_or[g] | cell_read[g * GROUP_SIZE + k];
				end
			end
		end
	end

	// second level: at most one group is nonzero, and only on a good pop
	always_comb begin
		all_or = '0;
		for (int g = 0; g < NUM_GROUPS; g++) begin
			all_or = all_or | grp_s1[g];
		end
	end

	always_ff @(posedge clk) begin
		if (accept) begin
			for (int g = 0; g < NUM_GROUPS; g++) begin
				grp_s1[g] <= grp_or[g];
			end
			status_s1 <= status;
		end
		if (s1_adv) begin
			data_q   <= tsb_pkg::from_word(all_or);
			status_q <= status_s1;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			s1_valid_q  <= 1'b0;
			out_valid_q <= 1'b0;
		end else begin
			if (accept) begin
				s1_valid_q <= 1'b1;
			end else if (s1_adv) begin
				s1_valid_q <= 1'b0;
			end
			if (s1_adv) begin
				out_valid_q <= 1'b1;
			end else if (m_tready) begin
				out_valid_q <= 1'b0;
			end
		end
	end

	assign m_tvalid = out_valid_q;
	assign m_tdata  = data_q;
	assign m_tuser  = status_q;

`ifndef ASSERT_OFF
	failed_data_zero_a: assert property (@(posedge clk) disable iff (!arst_n)
		m_tvalid && m_tuser != tsb_pkg::ST_OK |-> m_tdata == '0)
		else $error("failed request returned nonzero data");

	accept_fills_s1_a: assert property (@(posedge clk) disable iff (!arst_n)
		s_tvalid && s_tready |=> s1_valid_q)
		else $error("accepted beat lost before the read stage");

	s1_held_a: assert property (@(posedge clk) disable iff (!arst_n)
		s1_valid_q && !s1_adv |=> s1_valid_q && $stable(status_s1))
		else $error("read stage changed while stalled");
`endif

endmodule
